// ===== design/atas_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atas_pkg: shared types and constants for the ATA PIO sector sequencer
// Holds the channel payload structs, the operation and result codes, the
// task-file register offsets and the ATA status bits.
// ----------------------------------------------------------------------------
package atas_pkg;

  // Transfer geometry.
  localparam int WORDS_PER_SECTOR = 256;
  localparam int WORD_BITS        = $clog2(WORDS_PER_SECTOR);
  localparam int MAX_SECTORS      = 255;

  // Default depth of the queue between the front and back ends.
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Input operation codes.
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_DATA   = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_REG        = 3'd0;
  localparam logic [2:0] KIND_DATA_OUT   = 3'd1;
  localparam logic [2:0] KIND_WORD_HOST  = 3'd2;
  localparam logic [2:0] KIND_STATUS_REQ = 3'd3;
  localparam logic [2:0] KIND_DONE       = 3'd4;
  localparam logic [2:0] KIND_ERROR      = 3'd5;

  // Task-file register offsets.
  localparam logic [2:0] TF_NONE     = 3'd0;
  localparam logic [2:0] TF_SECCOUNT = 3'd2;
  localparam logic [2:0] TF_LBA_LOW  = 3'd3;
  localparam logic [2:0] TF_LBA_MID  = 3'd4;
  localparam logic [2:0] TF_LBA_HIGH = 3'd5;
  localparam logic [2:0] TF_DEVICE   = 3'd6;
  localparam logic [2:0] TF_COMMAND  = 3'd7;

  // ATA command bytes.
  localparam logic [7:0] ATA_CMD_READ    = 8'h20;
  localparam logic [7:0] ATA_CMD_WRITE   = 8'h30;
  localparam logic [7:0] ATA_CACHE_FLUSH = 8'hE7;

  // Status register bits.
  localparam int ST_BSY  = 7;
  localparam int ST_DRDY = 6;
  localparam int ST_DF   = 5;
  localparam int ST_DRQ  = 3;
  localparam int ST_ERR  = 0;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEVICE_BASE   = 2'd0;
  localparam logic [1:0] CFG_DRIVE_PRESENT = 2'd1;
  localparam logic [1:0] CFG_POLL_LIMIT    = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  DEVICE_BASE_RESET = 8'hE0;
  localparam logic [19:0] POLL_LIMIT_RESET  = 20'd100000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [27:0] block_address;
    logic [7:0]  sector_count;
    logic [7:0]  status_byte;
    logic [15:0] data_word;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  reg_index;
    logic [15:0] value;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [7:0]  device_base;
    logic        drive_present;
    logic [19:0] poll_limit;
  } cfg_t;

  // One queued request for the back end: either a full task-file burst or
  // one or two plain results.
  typedef struct packed {
    logic        taskfile;
    logic        two;
    logic [2:0]  kind_a;
    logic [2:0]  reg_a;
    logic [15:0] val_a;
    logic [2:0]  kind_b;
    logic        is_write;
    logic [27:0] lba;
    logic [7:0]  count;
    logic [7:0]  dsel;
  } desc_t;

endpackage
`default_nettype wire

// ===== design/ata_pio_sector_sequencer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ata_pio_sector_sequencer: host-side ATA PIO LBA28 read/write sequencer
// Polls drive status, writes the task file, moves sector data and flushes
// the drive cache after writes.
// ----------------------------------------------------------------------------
// The block takes one input request per cycle as long as its internal queue
// (QUEUE_DEPTH entries) has room, so data words can stream at full rate.
// Each request gives zero, one, two or seven results; the output side issues
// one result per cycle unless held off, from a single output register. The
// sample that finds the drive ready for the command issues seven results
// (six task-file writes and a status request); the last word of a sector and
// the flush write give two. Input stalls only when the output is held off or
// such a burst fills the queue. Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module ata_pio_sector_sequencer #(
  parameter int QUEUE_DEPTH = atas_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire atas_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output atas_pkg::result_t      result,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [19:0]       cfg_data
);
  import atas_pkg::*;

  cfg_t  cfg;
  logic  push_valid;
  logic  push_ready;
  desc_t push_desc;
  logic  pop_valid;
  logic  pop_ready;
  desc_t pop_desc;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_base   <= DEVICE_BASE_RESET;
      cfg.drive_present <= 1'b0;
      cfg.poll_limit    <= POLL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEVICE_BASE:   cfg.device_base   <= cfg_data[7:0];
        CFG_DRIVE_PRESENT: cfg.drive_present <= cfg_data[0];
        CFG_POLL_LIMIT:    cfg.poll_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  atas_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc)
  );

  atas_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_desc   (pop_desc)
  );

  atas_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_desc     (pop_desc),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  // Done and error always close the results of a request.
  a_terminal_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_DONE || result.kind == KIND_ERROR)
      |-> result.last)
    else $error("done or error result without last");

  // Register writes carry a byte to a real task-file register.
  a_reg_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_REG
      |-> result.value[15:8] == 8'd0 && result.reg_index >= TF_SECCOUNT)
    else $error("malformed task-file write");

  // Only register writes carry a register offset.
  a_reg_index_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_REG |-> result.reg_index == TF_NONE)
    else $error("register offset on a non-register result");

  // A status request never carries data.
  a_status_no_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_STATUS_REQ |-> result.value == 16'd0)
    else $error("status request with data");
`endif

endmodule
`default_nettype wire

// ===== design/atas_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atas_front: command and polling state machine
// Accepts input requests, tracks the transfer phase and counters, and
// pushes a description of the results each request causes into the queue.
// ----------------------------------------------------------------------------
module atas_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire atas_pkg::item_t item,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire atas_pkg::cfg_t  cfg,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output atas_pkg::desc_t      push_desc
);
  import atas_pkg::*;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_READY = 3'd1;
  localparam logic [2:0] PH_DRQ   = 3'd2;
  localparam logic [2:0] PH_DATA  = 3'd3;
  localparam logic [2:0] PH_POST  = 3'd4;
  localparam logic [2:0] PH_FLUSH = 3'd5;

  logic [2:0]           phase, phase_next;
  logic                 is_write, is_write_next;
  logic [27:0]          saved_lba, saved_lba_next;
  logic [7:0]           saved_count, saved_count_next;
  logic [7:0]           sectors_left, sectors_left_next;
  logic [WORD_BITS-1:0] word_index, word_index_next;
  logic [19:0]          poll_count, poll_count_next;

  logic        accept;
  logic        emit;
  logic [19:0] poll_inc;
  logic        timeout;
  logic        st_ready;
  logic        st_fault;
  logic        st_drq;
  logic        bad_start;
  logic [7:0]  sectors_dec;

  // Every request waits for queue room, even one that pushes nothing, so no description is ever dropped.
  assign item_ready = push_ready;
  assign accept     = item_valid && item_ready;
  assign push_valid = accept && emit;

  assign poll_inc    = poll_count + 20'd1;
  assign timeout     = poll_inc >= cfg.poll_limit;
  assign st_ready    = !item.status_byte[ST_BSY] && item.status_byte[ST_DRDY];
  assign st_fault    = item.status_byte[ST_ERR] || item.status_byte[ST_DF];
  assign st_drq      = !item.status_byte[ST_BSY] && item.status_byte[ST_DRQ];
  assign bad_start   = !cfg.drive_present || (item.sector_count == 8'd0) ||
                       (item.sector_count > 8'(MAX_SECTORS));
  assign sectors_dec = sectors_left - 8'd1;

  // Next state and the queued description for the current request.
  always_comb begin
    phase_next        = phase;
    is_write_next     = is_write;
    saved_lba_next    = saved_lba;
    saved_count_next  = saved_count;
    sectors_left_next = sectors_left;
    word_index_next   = word_index;
    poll_count_next   = poll_count;
    emit              = 1'b0;
    push_desc         = '0;
    push_desc.is_write = is_write;
    push_desc.lba      = saved_lba;
    push_desc.count    = saved_count;
    push_desc.dsel     = cfg.device_base;
    push_desc.kind_a   = KIND_STATUS_REQ;
    push_desc.reg_a    = TF_NONE;
    push_desc.kind_b   = KIND_STATUS_REQ;

    unique case (item.cmd)
      OP_READ, OP_WRITE: begin
        if (phase == PH_IDLE) begin
          emit = 1'b1;
          if (bad_start) begin
            push_desc.kind_a = KIND_ERROR;
          end else begin
            is_write_next     = item.cmd[0];
            saved_lba_next    = item.block_address;
            saved_count_next  = item.sector_count;
            sectors_left_next = item.sector_count;
            word_index_next   = '0;
            poll_count_next   = '0;
            phase_next        = PH_READY;
          end
        end
      end
      OP_STATUS: begin
        unique case (phase)
          PH_READY: begin
            emit = 1'b1;
            if (st_ready) begin
              push_desc.taskfile = 1'b1;
              poll_count_next    = '0;
              phase_next         = PH_DRQ;
            end else begin
              poll_count_next = poll_inc;
              if (timeout) begin
                push_desc.kind_a = KIND_ERROR;
                phase_next       = PH_IDLE;
              end
            end
          end
          PH_DRQ: begin
            if (st_fault) begin
              emit             = 1'b1;
              push_desc.kind_a = KIND_ERROR;
              phase_next       = PH_IDLE;
            end else if (st_drq) begin
              word_index_next = '0;
              poll_count_next = '0;
              phase_next      = PH_DATA;
            end else begin
              emit            = 1'b1;
              poll_count_next = poll_inc;
              if (timeout) begin
                push_desc.kind_a = KIND_ERROR;
                phase_next       = PH_IDLE;
              end
            end
          end
          PH_POST: begin
            emit = 1'b1;
            if (st_ready) begin
              push_desc.two    = 1'b1;
              push_desc.kind_a = KIND_REG;
              push_desc.reg_a  = TF_COMMAND;
              push_desc.val_a  = {8'd0, ATA_CACHE_FLUSH};
              poll_count_next  = '0;
              phase_next       = PH_FLUSH;
            end else begin
              poll_count_next = poll_inc;
              if (timeout) begin
                push_desc.kind_a = KIND_ERROR;
                phase_next       = PH_IDLE;
              end
            end
          end
          PH_FLUSH: begin
            // The flush wait ends as done even when it times out.
            emit = 1'b1;
            if (st_ready || timeout) begin
              push_desc.kind_a = KIND_DONE;
              phase_next       = PH_IDLE;
            end
            if (!st_ready) begin
              poll_count_next = poll_inc;
            end
          end
          default: begin
          end
        endcase
      end
      OP_DATA: begin
        if (phase == PH_DATA) begin
          emit             = 1'b1;
          push_desc.kind_a = is_write ? KIND_DATA_OUT : KIND_WORD_HOST;
          push_desc.val_a  = item.data_word;
          if (word_index == WORD_BITS'(WORDS_PER_SECTOR - 1)) begin
            push_desc.two     = 1'b1;
            word_index_next   = '0;
            sectors_left_next = sectors_dec;
            poll_count_next   = '0;
            if (sectors_dec != 8'd0) begin
              phase_next = PH_DRQ;
            end else if (is_write) begin
              phase_next = PH_POST;
            end else begin
              push_desc.kind_b = KIND_DONE;
              phase_next       = PH_IDLE;
            end
          end else begin
            word_index_next = word_index + WORD_BITS'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      is_write     <= 1'b0;
      saved_lba    <= '0;
      saved_count  <= '0;
      sectors_left <= '0;
      word_index   <= '0;
      poll_count   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      is_write     <= is_write_next;
      saved_lba    <= saved_lba_next;
      saved_count  <= saved_count_next;
      sectors_left <= sectors_left_next;
      word_index   <= word_index_next;
      poll_count   <= poll_count_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/atas_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atas_queue: short request queue between front and back ends
// A small register FIFO so the front can keep taking input while the back
// end is still expanding earlier requests or waiting on the output.
// ----------------------------------------------------------------------------
module atas_queue #(
  parameter int DEPTH = atas_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire atas_pkg::desc_t push_desc,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output atas_pkg::desc_t      pop_desc
);
  import atas_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_desc   = entries[rd_ptr];

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/atas_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// atas_back: result sequencer
// Takes queued requests and issues their results one per cycle unless held off
// into the output register, marking the final result of each request.
// ----------------------------------------------------------------------------
module atas_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_ready,
  input  wire atas_pkg::desc_t pop_desc,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output atas_pkg::result_t    result
);
  import atas_pkg::*;

  logic [2:0] step;
  logic [2:0] last_step;
  logic       load;
  logic       is_last;
  result_t    cur;

  assign load      = !result_valid || result_ready;
  assign last_step = pop_desc.taskfile ? 3'd6 : (pop_desc.two ? 3'd1 : 3'd0);
  assign is_last   = step == last_step;
  assign pop_ready = load && is_last;

  // Select the result for the current step of the head request.
  always_comb begin
    cur           = '0;
    cur.last      = is_last;
    cur.kind      = KIND_STATUS_REQ;
    cur.reg_index = TF_NONE;
    cur.value     = '0;
    if (pop_desc.taskfile) begin
      unique case (step)
        3'd0: begin
          cur.kind      = KIND_REG;
          cur.reg_index = TF_DEVICE;
          cur.value     = {8'd0, pop_desc.dsel | {4'd0, pop_desc.lba[27:24]}};
        end
        3'd1: begin
          cur.kind      = KIND_REG;
          cur.reg_index = TF_SECCOUNT;
          cur.value     = {8'd0, pop_desc.count};
        end
        3'd2: begin
          cur.kind      = KIND_REG;
          cur.reg_index = TF_LBA_LOW;
          cur.value     = {8'd0, pop_desc.lba[7:0]};
        end
        3'd3: begin
          cur.kind      = KIND_REG;
          cur.reg_index = TF_LBA_MID;
          cur.value     = {8'd0, pop_desc.lba[15:8]};
        end
        3'd4: begin
          cur.kind      = KIND_REG;
          cur.reg_index = TF_LBA_HIGH;
          cur.value     = {8'd0, pop_desc.lba[23:16]};
        end
        3'd5: begin
          cur.kind      = KIND_REG;
          cur.reg_index = TF_COMMAND;
          cur.value     = {8'd0, pop_desc.is_write ? ATA_CMD_WRITE
                                                   : ATA_CMD_READ};
        end
        default: begin
          cur.kind = KIND_STATUS_REQ;
        end
      endcase
    end else if (step == 3'd0) begin
      cur.kind      = pop_desc.kind_a;
      cur.reg_index = pop_desc.reg_a;
      cur.value     = pop_desc.val_a;
    end else begin
      cur.kind = pop_desc.kind_b;
    end
  end

  // Output register and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      step         <= '0;
    end else if (load) begin
      result_valid <= pop_valid;
      if (pop_valid) begin
        step <= is_last ? 3'd0 : step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && pop_valid) begin
      result <= cur;
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_ata_pio_sector_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_ata_pio_sector_sequencer: self-checking bench for the ATA PIO sequencer
// Drives start, status and data requests through the item channel, mirrors
// the sequencer in a cycle-free tracker and checks every result in order.
// Directed cases come first, then random sequences across several drive
// settings with varying back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_ata_pio_sector_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  import atas_pkg::*;

  localparam int SETTLE         = 32;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_ITEMS   = 30;
  localparam int MODE_SPAN      = 100;

  typedef enum logic [2:0] {
    PH_IDLE, PH_READY, PH_DRQ, PH_DATA, PH_POST, PH_FLUSH
  } seq_phase_e;

  typedef enum int {
    SAMPLE_READY, SAMPLE_NOT_READY, SAMPLE_DRQ, SAMPLE_DRQ_PENDING, SAMPLE_FAULT
  } sample_e;

  // Tracks the sequencer state and the results each request should cause.
  class txn_tracker;
    logic [7:0]  device_base;
    logic        drive_found;
    logic [19:0] poll_limit;
    seq_phase_e  phase;
    logic        writing;
    logic [27:0] lba;
    logic [7:0]  count;
    logic [7:0]  sectors_left;
    logic [7:0]  word_idx;
    logic [19:0] polls;
    result_t     burst [7];
    int          burst_len;
    result_t     pending_results [$];
    int          failures;
    int          checked;
    int          done_seen;
    int          errors_seen;

    function new();
      device_base  = DEVICE_BASE_RESET;
      drive_found  = 1'b0;
      poll_limit   = POLL_LIMIT_RESET;
      phase        = PH_IDLE;
      writing      = 1'b0;
      lba          = '0;
      count        = '0;
      sectors_left = '0;
      word_idx     = '0;
      polls        = '0;
      burst_len    = 0;
      failures     = 0;
      checked      = 0;
      done_seen    = 0;
      errors_seen  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] data);
      case (idx)
        CFG_DEVICE_BASE:   device_base = data[7:0];
        CFG_DRIVE_PRESENT: drive_found = data[0];
        CFG_POLL_LIMIT:    poll_limit  = data;
        default: ;
      endcase
    endfunction

    function void queue_result(logic [2:0] kind, logic [2:0] idx, logic [15:0] val);
      result_t r;
      r.kind      = kind;
      r.reg_index = idx;
      r.value     = val;
      r.last      = 1'b0;
      if (burst_len < 7) begin
        burst[burst_len] = r;
        burst_len++;
      end
    endfunction

    function bit drive_ready(logic [7:0] s);
      return !s[ST_BSY] && s[ST_DRDY];
    endfunction

    // Counts one failing sample; true once the wait has used up its budget.
    function bit poll_expired();
      polls = polls + 20'd1;
      return polls >= poll_limit;
    endfunction

    // Advances the state for one accepted request and queues its results.
    // Returns one when the request had any effect at all.
    function bit accept_request(item_t it);
      seq_phase_e was;
      result_t    r;
      was = phase;
      burst_len = 0;
      case (it.cmd)
        OP_READ, OP_WRITE: begin
          if (phase == PH_IDLE) begin
            if (!drive_found || it.sector_count == 0 || it.sector_count > MAX_SECTORS) begin
              queue_result(KIND_ERROR, TF_NONE, 16'h0);
            end else begin
              writing      = (it.cmd == OP_WRITE);
              lba          = it.block_address;
              count        = it.sector_count;
              sectors_left = it.sector_count;
              word_idx     = '0;
              polls        = '0;
              phase        = PH_READY;
              queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
            end
          end
        end
        OP_STATUS: begin
          case (phase)
            PH_READY: begin
              if (drive_ready(it.status_byte)) begin
                queue_result(KIND_REG, TF_DEVICE, {8'h00, device_base | {4'h0, lba[27:24]}});
                queue_result(KIND_REG, TF_SECCOUNT, {8'h00, count});
                queue_result(KIND_REG, TF_LBA_LOW, {8'h00, lba[7:0]});
                queue_result(KIND_REG, TF_LBA_MID, {8'h00, lba[15:8]});
                queue_result(KIND_REG, TF_LBA_HIGH, {8'h00, lba[23:16]});
                queue_result(KIND_REG, TF_COMMAND,
                             {8'h00, writing ? ATA_CMD_WRITE : ATA_CMD_READ});
                queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
                polls = '0;
                phase = PH_DRQ;
              end else if (poll_expired()) begin
                queue_result(KIND_ERROR, TF_NONE, 16'h0);
                phase = PH_IDLE;
              end else begin
                queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
              end
            end
            PH_DRQ: begin
              if (it.status_byte[ST_ERR] || it.status_byte[ST_DF]) begin
                queue_result(KIND_ERROR, TF_NONE, 16'h0);
                phase = PH_IDLE;
              end else if (!it.status_byte[ST_BSY] && it.status_byte[ST_DRQ]) begin
                word_idx = '0;
                polls    = '0;
                phase    = PH_DATA;
              end else if (poll_expired()) begin
                queue_result(KIND_ERROR, TF_NONE, 16'h0);
                phase = PH_IDLE;
              end else begin
                queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
              end
            end
            PH_POST: begin
              if (drive_ready(it.status_byte)) begin
                queue_result(KIND_REG, TF_COMMAND, {8'h00, ATA_CACHE_FLUSH});
                queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
                polls = '0;
                phase = PH_FLUSH;
              end else if (poll_expired()) begin
                queue_result(KIND_ERROR, TF_NONE, 16'h0);
                phase = PH_IDLE;
              end else begin
                queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
              end
            end
            PH_FLUSH: begin
              // The flush wait finishes as done even when it runs out of polls.
              if (drive_ready(it.status_byte) || poll_expired()) begin
                queue_result(KIND_DONE, TF_NONE, 16'h0);
                phase = PH_IDLE;
              end else begin
                queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
              end
            end
            default: ;
          endcase
        end
        default: begin
          if (phase == PH_DATA) begin
            queue_result(writing ? KIND_DATA_OUT : KIND_WORD_HOST, TF_NONE, it.data_word);
            if (int'(word_idx) + 1 >= WORDS_PER_SECTOR) begin
              word_idx     = '0;
              sectors_left = sectors_left - 8'd1;
              polls        = '0;
              if (sectors_left != 0) begin
                phase = PH_DRQ;
                queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
              end else if (writing) begin
                phase = PH_POST;
                queue_result(KIND_STATUS_REQ, TF_NONE, 16'h0);
              end else begin
                phase = PH_IDLE;
                queue_result(KIND_DONE, TF_NONE, 16'h0);
              end
            end else begin
              word_idx = word_idx + 8'd1;
            end
          end
        end
      endcase

      // The final result of each request carries the last flag.
      for (int i = 0; i < burst_len; i++) begin
        r = burst[i];
        r.last = (i == burst_len - 1);
        pending_results.push_back(r);
      end
      return (burst_len != 0) || (phase != was);
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result kind=%0d reg=%0d value=%h last=%b, none expected",
                 $time, got.kind, got.reg_index, got.value, got.last);
        return;
      end
      want = pending_results.pop_front();
      if (want.kind == KIND_DONE) done_seen++;
      if (want.kind == KIND_ERROR) errors_seen++;
      if (got.kind !== want.kind || got.reg_index !== want.reg_index ||
          got.value !== want.value || got.last !== want.last) begin
        failures++;
        $display("%0t: result mismatch, expected kind=%0d reg=%0d value=%h last=%b, %s",
                 $time, want.kind, want.reg_index, want.value, want.last,
                 $sformatf("actual kind=%0d reg=%0d value=%h last=%b",
                           got.kind, got.reg_index, got.value, got.last));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  item_t       item = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  txn_tracker  tracker = new();
  int          items_done = 0;
  int          settings_done = 0;
  int          send_idle_pct = 13;
  int          recv_idle_pct = 60;
  bit          holdoff_req = 1'b0;
  int          holdoff_left = 0;

  ata_pio_sector_sequencer uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic item_t random_request(logic [1:0] op);
    item_t it;
    it.cmd           = op;
    it.block_address = 28'($urandom);
    it.sector_count  = 8'($urandom);
    it.status_byte   = 8'($urandom);
    it.data_word     = 16'($urandom);
    return it;
  endfunction

  // Builds a status byte of the requested flavor with the other bits random.
  function automatic logic [7:0] make_status(sample_e what);
    logic [7:0] s;
    s = 8'($urandom);
    case (what)
      SAMPLE_READY: begin
        s[ST_BSY]  = 1'b0;
        s[ST_DRDY] = 1'b1;
      end
      SAMPLE_NOT_READY: begin
        if (chance(50)) s[ST_BSY] = 1'b1;
        else s[ST_DRDY] = 1'b0;
      end
      SAMPLE_DRQ: begin
        s[ST_BSY] = 1'b0;
        s[ST_DRQ] = 1'b1;
        s[ST_ERR] = 1'b0;
        s[ST_DF]  = 1'b0;
      end
      SAMPLE_DRQ_PENDING: begin
        s[ST_ERR] = 1'b0;
        s[ST_DF]  = 1'b0;
        if (chance(50)) s[ST_BSY] = 1'b1;
        else s[ST_DRQ] = 1'b0;
      end
      default: begin
        case ($urandom_range(2))
          0: s[ST_ERR] = 1'b1;
          1: s[ST_DF] = 1'b1;
          default: begin
            s[ST_ERR] = 1'b1;
            s[ST_DF]  = 1'b1;
          end
        endcase
      end
    endcase
    return s;
  endfunction

  // Offers one request, with random gaps ahead of it, and logs it on acceptance.
  task automatic send_item(input item_t it);
    if (items_done >= 2 * MODE_SPAN) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (items_done >= MODE_SPAN) begin
      send_idle_pct = 60;
      recv_idle_pct = 13;
    end
    while (chance(send_idle_pct)) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    if (tracker.accept_request(it)) items_done++;
  endtask

  task automatic send_start(input logic [1:0] op, input logic [27:0] lba,
                            input logic [7:0] cnt);
    item_t it;
    it = random_request(op);
    it.block_address = lba;
    it.sector_count  = cnt;
    send_item(it);
  endtask

  task automatic send_status(input sample_e what);
    item_t it;
    it = random_request(OP_STATUS);
    it.status_byte = make_status(what);
    send_item(it);
  endtask

  // Stops offering requests until every expected result has come back.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(posedge clk); while (tracker.pending_results.size() != 0);
  endtask

  // Rewrites all three drive registers once the sequencer has gone quiet.
  task automatic program_drive(input logic [7:0] dsel, input logic present,
                               input logic [19:0] limit);
    logic [1:0]  regs [3];
    logic [19:0] vals [3];
    int          i;
    regs[0] = CFG_DEVICE_BASE;
    regs[1] = CFG_DRIVE_PRESENT;
    regs[2] = CFG_POLL_LIMIT;
    vals[0] = {12'($urandom), dsel};
    vals[1] = {19'($urandom), present};
    vals[2] = limit;
    drain_results();
    repeat (SETTLE) @(posedge clk);
    for (i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      tracker.write_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    settings_done++;
  endtask

  // Runs one command from start to the return to idle, answering each wait
  // with samples drawn from the given odds and mixing in stray requests.
  task automatic play_transaction(input logic [1:0] op, input logic [27:0] lba,
                                  input logic [7:0] cnt, input int ready_miss,
                                  input int drq_miss, input int flush_miss,
                                  input int fault_pct, input int noise_pct);
    logic [1:0] stray;
    send_start(op, lba, cnt);
    while (tracker.phase != PH_IDLE) begin
      if (chance(noise_pct)) begin
        if (chance(30)) stray = chance(50) ? OP_READ : OP_WRITE;
        else stray = (tracker.phase == PH_DATA) ? OP_STATUS : OP_DATA;
        send_item(random_request(stray));
      end else begin
        case (tracker.phase)
          PH_READY, PH_POST:
            send_status(chance(ready_miss) ? SAMPLE_NOT_READY : SAMPLE_READY);
          PH_FLUSH:
            send_status(chance(flush_miss) ? SAMPLE_NOT_READY : SAMPLE_READY);
          PH_DRQ: begin
            if (chance(fault_pct)) send_status(SAMPLE_FAULT);
            else send_status(chance(drq_miss) ? SAMPLE_DRQ_PENDING : SAMPLE_DRQ);
          end
          default: send_item(random_request(OP_DATA));
        endcase
      end
    end
  endtask

  // Result side: checks each accepted result and applies back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) tracker.check_result(result);
      if (holdoff_req) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_req  = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= !chance(recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int          stop_at;
    logic [19:0] limit;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // With reset settings no drive is present, so a start is refused, and
    // samples or words while idle are dropped.
    send_start(OP_WRITE, 28'hFFFFFFF, 8'd1);
    send_item(random_request(OP_STATUS));
    send_item(random_request(OP_DATA));

    // A zero count is refused; with no poll budget the first miss times out.
    program_drive(8'h00, 1'b1, 20'd0);
    send_start(OP_READ, 28'h0000000, 8'd0);
    send_start(OP_READ, 28'hFFFFFFF, 8'd255);
    send_status(SAMPLE_NOT_READY);

    // Full task-file burst at the widest count, then a timeout waiting for DRQ.
    program_drive(8'hFF, 1'b1, 20'd1);
    send_start(OP_WRITE, 28'h0000000, 8'd255);
    send_status(SAMPLE_READY);
    send_status(SAMPLE_DRQ_PENDING);

    // A start while busy and a stray word are dropped; a fault ends the DRQ wait.
    program_drive(DEVICE_BASE_RESET, 1'b1, 20'd3);
    send_start(OP_READ, 28'($urandom), 8'd1);
    send_start(OP_WRITE, 28'($urandom), 8'd1);
    send_item(random_request(OP_DATA));
    send_status(SAMPLE_NOT_READY);
    send_status(SAMPLE_NOT_READY);
    send_status(SAMPLE_READY);
    send_status(SAMPLE_DRQ_PENDING);
    send_status(SAMPLE_FAULT);
    send_start(OP_WRITE, 28'($urandom), 8'($urandom_range(255, 1)));
    send_status(SAMPLE_READY);
    send_status(SAMPLE_FAULT);

    // One full sector written while the result side stalls for a long
    // stretch; the flush wait then runs out of polls and still ends as done.
    program_drive(8'($urandom), 1'b1, 20'd2);
    holdoff_req = 1'b1;
    play_transaction(OP_WRITE, 28'($urandom), 8'd1, 0, 0, 100, 0, 3);

    // Random sequences over changing drive settings. A command that gets past
    // the ready wait ends in the DRQ wait, by a fault or by running out of polls,
    // so a sector of data never has to be moved here.
    stop_at = items_done + RANDOM_ITEMS;
    while (items_done < stop_at) begin
      if (chance(20)) begin
        case ($urandom_range(1))
          0: limit = 20'($urandom_range(4, 1));
          default: limit = 20'($urandom_range(8, 5));
        endcase
        program_drive(8'($urandom), chance(90), limit);
      end else if (chance(10)) begin
        drain_results();
      end
      case ($urandom_range(9))
        0: play_transaction(chance(50) ? OP_READ : OP_WRITE, 28'($urandom), 8'd0,
                            0, 0, 0, 0, 0);
        1: send_item(random_request(chance(50) ? OP_STATUS : OP_DATA));
        2, 3, 4, 5:
          play_transaction(chance(50) ? OP_READ : OP_WRITE, 28'($urandom),
                           8'($urandom_range(255, 1)), 25, 100, 25, 25, 5);
        default:
          play_transaction(chance(50) ? OP_READ : OP_WRITE, 28'($urandom),
                           8'($urandom), 40, 100, 40, 50, 5);
      endcase
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    $display("Run covered %0d effective requests over %0d drive settings.",
             items_done, settings_done);
    $display("Checked %0d results, including %0d completions and %0d errors.",
             tracker.checked, tracker.done_seen, tracker.errors_seen);
    if (tracker.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
